FILE: rtl/nmc_pkg.sv
// Shared types and constants of the normalized mask correlation block.
package nmc_pkg;

    // Fixed field widths of the pixel, result and configuration words.
    localparam int PIX_W   = 8;
    localparam int POS_W   = 11;
    localparam int DIM_W   = 12;
    localparam int MDIM_W  = 3;
    localparam int CFG_W   = 64;
    localparam int CIDX_W  = 3;
    localparam int COEF_W  = 8;
    localparam int MASK_CFG_W = 3 * CFG_W + COEF_W;
    localparam int NCOEF_CFG  = 25;

    // Arithmetic widths: the mask sum, product, accumulator and divider.
    localparam int SUM_W  = 13;
    localparam int PROD_W = COEF_W + PIX_W + 1;
    localparam int ACC_W  = 22;
    localparam int DCW    = $clog2(ACC_W);
    localparam int MNW    = 2 * MDIM_W;

    typedef logic [PIX_W-1:0]  t_pixel;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [CIDX_W-1:0] t_cfg_idx;
    typedef logic [CFG_W-1:0]  t_cfg_data;

    // Configuration register indexes.
    typedef enum logic [CIDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_MASK_WIDTH   = 3'd2,
        REG_MASK_HEIGHT  = 3'd3,
        REG_MASK_WORD_0  = 3'd4,
        REG_MASK_WORD_1  = 3'd5,
        REG_MASK_WORD_2  = 3'd6,
        REG_MASK_WORD_3  = 3'd7
    } t_reg_idx;

    // Register reset values.
    localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [MDIM_W-1:0] RST_MASK_DIM     = 3'd3;

endpackage

FILE: rtl/normalized_mask_correlation.sv
// Normalized mask correlation: streaming grey frame through a line store and mask window.
//
// Pixels enter in raster order on the input channel (i_valid, o_ready, i_pixel); one
// result word per pixel leaves on the output channel (o_valid, i_ready). The line store
// is one synchronous memory, one entry per column holding that column of every stored
// row, so each pixel costs one read and one write-back of the same entry.
// Geometry and mask coefficients are written on the plain configuration port and are
// taken over on the first pixel of a frame; the user must write them only while the
// block is idle, which the block itself does not enforce.
// Border pixels and size errors skip the mask taps; an interior pixel runs the mask
// taps, and the divider too when the mask sum is neither 0 nor 1. The first pixel of
// a frame with valid geometry forms the mask sum before going on. One shared
// multiplier does one mask tap per cycle and the divider retires one quotient bit per
// cycle. A pixel is taken only in the idle state, in the cycle after the previous
// result lands, so one pixel is in work at a time.
// A stalled receiver holds the result in the output register; the next pixel is still
// taken and worked on, and waits for the register to drain before its result lands.
// Reset (synchronous, active low) restores the register defaults, clears the frame
// counters and empties the output register; the line store is not cleared.
module normalized_mask_correlation #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_MASK  = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  nmc_pkg::t_pixel      i_pixel,
    output logic                 o_valid,
    input  logic                 i_ready,
    output nmc_pkg::t_pixel      o_out_value,
    output nmc_pkg::t_pos        o_out_row,
    output nmc_pkg::t_pos        o_out_col,
    output logic                 o_interior,
    output logic                 o_size_error,
    output logic                 o_frame_last,
    input  logic                 i_cfg_we,
    input  nmc_pkg::t_cfg_idx    i_cfg_addr,
    input  nmc_pkg::t_cfg_data   i_cfg_wdata
);
    import nmc_pkg::*;

    localparam int GB   = $clog2(MAX_WIDTH + 1);
    localparam int GW   = ((GB > DIM_W) ? GB : DIM_W) + 1;
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int RING = MAX_MASK - 1;
    localparam int RW   = $clog2(RING);
    localparam int MI   = $clog2(MAX_MASK);
    localparam int NC   = MAX_MASK * MAX_MASK;
    localparam int CI   = $clog2(NC + 1);
    localparam int CIX  = $clog2(NC);
    localparam int NX   = (NC > NCOEF_CFG) ? NC : NCOEF_CFG;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_MSUM, S_MAC, S_POST, S_DIV, S_FIN, S_RESULT
    } t_state;

    // Configuration registers.
    logic [DIM_W-1:0]       r_cfg_w, r_cfg_h;
    logic [MDIM_W-1:0]      r_cfg_mw, r_cfg_mh;
    logic [MASK_CFG_W-1:0]  r_cfg_mask;

    // Geometry and mask taken over at frame start.
    logic [DIM_W-1:0]          r_act_w, r_act_h;
    logic [MDIM_W-1:0]         r_act_mw, r_act_mh;
    logic [GW-1:0]             r_eff_w, r_eff_h;
    logic                      r_err;
    logic [MNW-1:0]            r_mn;
    logic signed [COEF_W-1:0]  r_coef [NC];
    logic signed [SUM_W-1:0]   r_msum;

    // Frame counters and the pixel in work.
    logic [GW-1:0]     r_row, r_col, r_cur_row, r_cur_col;
    logic [RW-1:0]     r_rs, r_cur_rs;
    logic [PIX_W-1:0]  r_pix;
    logic              r_first;
    logic [PIX_W-1:0]  r_win [MAX_MASK][MAX_MASK];

    // Line store.
    logic [RING*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [RING*PIX_W-1:0] r_rdata;
    logic [RING*PIX_W-1:0] mem_wdata;

    // Compute datapath.
    t_state                   r_state;
    logic                     r_inner, r_last;
    logic [GW-1:0]            r_cr, r_cc;
    logic [CI-1:0]            r_k, r_j;
    logic [MDIM_W-1:0]        r_mr, r_mc;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]         r_dvd;
    logic [SUM_W-1:0]         r_dvs, r_rem;
    logic                     r_neg;
    logic [DCW-1:0]           r_dcnt;
    logic [PIX_W-1:0]         r_value;

    // Output register.
    logic             r_o_valid, r_o_interior, r_o_err, r_o_last;
    logic [PIX_W-1:0] r_o_value;
    logic [POS_W-1:0] r_o_row, r_o_col;

    logic accept, frame_start;

    assign o_ready      = (r_state == S_IDLE);
    assign accept       = i_valid && o_ready;
    assign frame_start  = (r_row == '0) && (r_col == '0);
    assign o_valid      = r_o_valid;
    assign o_out_value  = r_o_value;
    assign o_out_row    = r_o_row;
    assign o_out_col    = r_o_col;
    assign o_interior   = r_o_interior;
    assign o_size_error = r_o_err;
    assign o_frame_last = r_o_last;

    // Geometry check and clamping of the configured frame size.
    logic              lat_err;
    logic [GW-1:0]     lat_eff_w, lat_eff_h;
    logic [NX*8-1:0]   mask_ext;

    always_comb begin
        lat_err = (r_cfg_w == '0) || (GW'(r_cfg_w) > GW'(MAX_WIDTH)) ||
                  (r_cfg_h == '0) || (GW'(r_cfg_h) > GW'(MAX_WIDTH)) ||
                  (r_cfg_mw == '0) || ({1'b0, r_cfg_mw} > (MDIM_W+1)'(MAX_MASK)) ||
                  (r_cfg_mh == '0) || ({1'b0, r_cfg_mh} > (MDIM_W+1)'(MAX_MASK)) ||
                  (DIM_W'(r_cfg_mw) > r_cfg_w) || (DIM_W'(r_cfg_mh) > r_cfg_h);
        lat_eff_w = (r_cfg_w == '0) ? GW'(1) :
                    ((GW'(r_cfg_w) > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : GW'(r_cfg_w));
        lat_eff_h = (r_cfg_h == '0) ? GW'(1) :
                    ((GW'(r_cfg_h) > GW'(MAX_WIDTH)) ? GW'(MAX_WIDTH) : GW'(r_cfg_h));
        mask_ext  = (NX*8)'(r_cfg_mask);
    end

    // Window column from the line store, and the write-back entry.
    logic [PIX_W-1:0] new_col [MAX_MASK];
    logic [RW:0]      slot_w;
    logic [RW-1:0]    slot;

    always_comb begin
        new_col[0] = r_pix;
        slot_w = '0;
        slot = '0;
        for (int d = 1; d <= RING; d++) begin
            slot_w = {1'b0, r_cur_rs} + (RW+1)'(RING - d);
            slot = (slot_w >= (RW+1)'(RING)) ? RW'(slot_w - (RW+1)'(RING)) : RW'(slot_w);
            new_col[d] = '0;
            for (int s = 0; s < RING; s++) begin
                if (RW'(s) == slot) begin
                    new_col[d] = r_rdata[s*PIX_W +: PIX_W];
                end
            end
        end
        for (int s = 0; s < RING; s++) begin
            mem_wdata[s*PIX_W +: PIX_W] = (RW'(s) == r_cur_rs) ? r_pix
                                                                : r_rdata[s*PIX_W +: PIX_W];
        end
    end

    // Window position of the pixel in work.
    logic [GW-1:0] row1, col1, mhg, mwg, cr, cc;
    logic          win_ok, inner, last;

    always_comb begin
        row1   = r_cur_row + GW'(1);
        col1   = r_cur_col + GW'(1);
        mhg    = GW'(r_act_mh);
        mwg    = GW'(r_act_mw);
        win_ok = !r_err && (row1 >= mhg) && (col1 >= mwg);
        cr     = row1 - mhg + (mhg >> 1);
        cc     = col1 - mwg + (mwg >> 1);
        inner  = win_ok && (cr < GW'(r_act_h) - (mhg >> 1)) &&
                 (cc < GW'(r_act_w) - (mwg >> 1));
        last   = (r_cur_row == r_eff_h - GW'(1)) && (r_cur_col == r_eff_w - GW'(1));
    end

    // Mask tap for the current product.
    logic [MDIM_W-1:0]         tap_d, tap_k;
    logic [PIX_W-1:0]          tap_pix;
    logic signed [PROD_W-1:0]  tap_prod;

    always_comb begin
        tap_d    = r_act_mh - MDIM_W'(1) - r_mr;
        tap_k    = r_act_mw - MDIM_W'(1) - r_mc;
        tap_pix  = r_win[tap_d[MI-1:0]][tap_k[MI-1:0]];
        tap_prod = r_coef[r_j[CIX-1:0]] * $signed({1'b0, tap_pix});
    end

    // Rounding offset and operand magnitudes for the divider.
    logic signed [SUM_W-1:0] half;
    logic signed [ACC_W-1:0] numer;
    logic [SUM_W:0]          trial;

    always_comb begin
        // Half the mask sum, truncated toward zero.
        half  = $signed(r_msum + SUM_W'(r_msum[SUM_W-1])) >>> 1;
        numer = r_acc + ACC_W'(half);
        trial = {r_rem, r_dvd[ACC_W-1]};
    end

    // Line store: read at accept, write back in the following cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= r_mem[r_col[AW-1:0]];
        end
        if (r_state == S_LOAD) begin
            r_mem[r_cur_col[AW-1:0]] <= mem_wdata;
        end
    end

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= RST_IMAGE_WIDTH;
            r_cfg_h    <= RST_IMAGE_HEIGHT;
            r_cfg_mw   <= RST_MASK_DIM;
            r_cfg_mh   <= RST_MASK_DIM;
            r_cfg_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_wdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_wdata[DIM_W-1:0];
                REG_MASK_WIDTH:   r_cfg_mw <= i_cfg_wdata[MDIM_W-1:0];
                REG_MASK_HEIGHT:  r_cfg_mh <= i_cfg_wdata[MDIM_W-1:0];
                REG_MASK_WORD_0:  r_cfg_mask[0 +: CFG_W] <= i_cfg_wdata;
                REG_MASK_WORD_1:  r_cfg_mask[CFG_W +: CFG_W] <= i_cfg_wdata;
                REG_MASK_WORD_2:  r_cfg_mask[2*CFG_W +: CFG_W] <= i_cfg_wdata;
                REG_MASK_WORD_3:  r_cfg_mask[3*CFG_W +: COEF_W] <= i_cfg_wdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, datapath and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_rs      <= '0;
            r_o_valid <= 1'b0;
            r_msum    <= '0;
            r_err     <= 1'b0;
            r_eff_w   <= GW'(1);
            r_eff_h   <= GW'(1);
        end else begin
            // The result state reloads the output register itself.
            if (r_o_valid && i_ready && (r_state != S_RESULT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_pix     <= i_pixel;
                        r_cur_row <= r_row;
                        r_cur_col <= r_col;
                        r_cur_rs  <= r_rs;
                        r_first   <= frame_start;
                        r_k       <= '0;
                        if (frame_start) begin
                            r_act_w  <= r_cfg_w;
                            r_act_h  <= r_cfg_h;
                            r_act_mw <= r_cfg_mw;
                            r_act_mh <= r_cfg_mh;
                            r_eff_w  <= lat_eff_w;
                            r_eff_h  <= lat_eff_h;
                            r_err    <= lat_err;
                            r_mn     <= MNW'(r_cfg_mw) * MNW'(r_cfg_mh);
                            r_msum   <= '0;
                            for (int k = 0; k < NC; k++) begin
                                r_coef[k] <= $signed(mask_ext[k*8 +: 8]);
                            end
                        end
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    for (int d = 0; d < MAX_MASK; d++) begin
                        for (int k = MAX_MASK - 1; k > 0; k--) begin
                            r_win[d][k] <= r_win[d][k-1];
                        end
                        r_win[d][0] <= new_col[d];
                    end
                    r_inner <= inner;
                    r_last  <= last;
                    r_cr    <= inner ? cr : '0;
                    r_cc    <= inner ? cc : '0;
                    r_value <= '0;
                    r_j     <= '0;
                    r_mr    <= '0;
                    r_mc    <= '0;
                    r_pv    <= 1'b0;
                    r_acc   <= '0;
                    // Advance the frame counters.
                    if (col1 >= r_eff_w) begin
                        r_col <= '0;
                        if (row1 >= r_eff_h) begin
                            r_row <= '0;
                            r_rs  <= '0;
                        end else begin
                            r_row <= row1;
                            r_rs  <= (r_cur_rs == RW'(RING - 1)) ? '0 : r_cur_rs + RW'(1);
                        end
                    end else begin
                        r_col <= col1;
                    end
                    if (r_first && !r_err) begin
                        r_state <= S_MSUM;
                    end else if (inner) begin
                        r_state <= S_MAC;
                    end else begin
                        r_state <= S_RESULT;
                    end
                end
                S_MSUM: begin
                    // One coefficient of the mask sum per cycle.
                    if (MNW'(r_k) < r_mn) begin
                        r_msum <= r_msum + SUM_W'(r_coef[r_k[CIX-1:0]]);
                        r_k    <= r_k + CI'(1);
                    end else begin
                        r_state <= r_inner ? S_MAC : S_RESULT;
                    end
                end
                S_MAC: begin
                    // One mask tap per cycle, product registered before the add.
                    if (r_pv) begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                    if (MNW'(r_j) < r_mn) begin
                        r_prod <= tap_prod;
                        r_pv   <= 1'b1;
                        r_j    <= r_j + CI'(1);
                        if (r_mc == r_act_mw - MDIM_W'(1)) begin
                            r_mc <= '0;
                            r_mr <= r_mr + MDIM_W'(1);
                        end else begin
                            r_mc <= r_mc + MDIM_W'(1);
                        end
                    end else begin
                        r_pv    <= 1'b0;
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (r_msum == '0 || r_msum == SUM_W'(1)) begin
                        r_value <= r_acc[ACC_W-1] ? '0 :
                                   ((r_acc > ACC_W'(255)) ? PIX_W'(255) : r_acc[PIX_W-1:0]);
                        r_state <= S_RESULT;
                    end else begin
                        r_dvd   <= numer[ACC_W-1] ? ACC_W'(-numer) : ACC_W'(numer);
                        r_dvs   <= r_msum[SUM_W-1] ? SUM_W'(-r_msum) : SUM_W'(r_msum);
                        r_neg   <= numer[ACC_W-1] ^ r_msum[SUM_W-1];
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    if (trial >= {1'b0, r_dvs}) begin
                        r_rem <= SUM_W'(trial - {1'b0, r_dvs});
                        r_dvd <= {r_dvd[ACC_W-2:0], 1'b1};
                    end else begin
                        r_rem <= SUM_W'(trial);
                        r_dvd <= {r_dvd[ACC_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (r_dcnt == DCW'(ACC_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_value <= r_neg ? '0 :
                               ((r_dvd > ACC_W'(255)) ? PIX_W'(255) : r_dvd[PIX_W-1:0]);
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    // Wait for the output register to drain.
                    if (!r_o_valid || i_ready) begin
                        r_o_valid    <= 1'b1;
                        r_o_value    <= r_inner ? r_value : '0;
                        r_o_row      <= POS_W'(r_cr);
                        r_o_col      <= POS_W'(r_cc);
                        r_o_interior <= r_inner;
                        r_o_err      <= r_err;
                        r_o_last     <= r_last;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A word marked as a size error never carries an interior result.
    a_err_not_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_interior && r_o_err))
        else $error("interior result reported with a size error");

    // Border words carry zero value and position.
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_interior) |->
            (r_o_value == '0 && r_o_row == '0 && r_o_col == '0))
        else $error("border word with nonzero payload");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0))
        else $error("divider started with zero divisor");

    // The line store is only written inside the active row width.
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_cur_col < r_eff_w))
        else $error("line store column out of range");

endmodule
